// File: rtl/ttrt_pkg.sv
// Shared types and codes for the timed threshold relay trigger unit.
package ttrt_pkg;

    // Command codes sent to the driven output
    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_ON     = 3'd1,
        CMD_OFF    = 3'd2,
        CMD_REVIVE = 3'd3,
        CMD_KILL   = 3'd4
    } t_cmd;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_WINDOW_START  = 3'd0,
        REG_WINDOW_END    = 3'd1,
        REG_ENABLE_MODE   = 3'd2,
        REG_ON_MODE       = 3'd3,
        REG_ON_THRESHOLD  = 3'd4,
        REG_OFF_MODE      = 3'd5,
        REG_OFF_THRESHOLD = 3'd6,
        REG_OPTION_FLAGS  = 3'd7
    } t_reg_idx;

    // Enable modes
    localparam logic [1:0] EN_DISABLED = 2'd0;
    localparam logic [1:0] EN_TIMED    = 2'd1;
    localparam logic [1:0] EN_FORCED   = 2'd2;

    // Rule modes, shared by the on rule and the off rule
    localparam logic [1:0] RULE_NONE  = 2'd0;
    localparam logic [1:0] RULE_BELOW = 2'd1;
    localparam logic [1:0] RULE_ABOVE = 2'd2;
    localparam logic [1:0] RULE_TIMER = 2'd3;

    // Option flag bit positions
    localparam int unsigned OPT_IMPORTANT = 0;
    localparam int unsigned OPT_PRESENT   = 1;

    // Window value that marks an all-day window
    localparam logic signed [11:0] WINDOW_ALL_DAY = -12'sd1;

    // Configuration register file contents
    typedef struct packed {
        logic signed [11:0] window_start;
        logic signed [11:0] window_end;
        logic [1:0]         enable_mode;
        logic [1:0]         on_mode;
        logic signed [15:0] on_threshold;
        logic [1:0]         off_mode;
        logic signed [15:0] off_threshold;
        logic [1:0]         option_flags;
    } t_cfg;

    // One tick item
    typedef struct packed {
        logic [10:0]        minute_of_day;
        logic signed [15:0] sensor_value;
        logic               output_is_on;
        logic [31:0]        output_uptime;
    } t_item;

    // One result item
    typedef struct packed {
        t_cmd first_command;
        t_cmd second_command;
        logic trigger_on;
        logic handled;
    } t_result;

endpackage

// File: rtl/ttrt_cfg_regs.sv
// Configuration register file with APB-style write and read access.
module ttrt_cfg_regs
    import ttrt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    // Write the addressed register at the end of the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_start  <= WINDOW_ALL_DAY;
            r_cfg.window_end    <= WINDOW_ALL_DAY;
            r_cfg.enable_mode   <= EN_DISABLED;
            r_cfg.on_mode       <= RULE_NONE;
            r_cfg.on_threshold  <= '0;
            r_cfg.off_mode      <= RULE_NONE;
            r_cfg.off_threshold <= '0;
            r_cfg.option_flags  <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_WINDOW_START:  r_cfg.window_start  <= pwdata[11:0];
                REG_WINDOW_END:    r_cfg.window_end    <= pwdata[11:0];
                REG_ENABLE_MODE:   r_cfg.enable_mode   <= pwdata[1:0];
                REG_ON_MODE:       r_cfg.on_mode       <= pwdata[1:0];
                REG_ON_THRESHOLD:  r_cfg.on_threshold  <= pwdata[15:0];
                REG_OFF_MODE:      r_cfg.off_mode      <= pwdata[1:0];
                REG_OFF_THRESHOLD: r_cfg.off_threshold <= pwdata[15:0];
                REG_OPTION_FLAGS:  r_cfg.option_flags  <= pwdata[1:0];
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    // Return the addressed register, signed fields sign-extended
    always_comb begin
        unique case (w_idx)
            REG_WINDOW_START:  prdata = {{20{r_cfg.window_start[11]}}, r_cfg.window_start};
            REG_WINDOW_END:    prdata = {{20{r_cfg.window_end[11]}}, r_cfg.window_end};
            REG_ENABLE_MODE:   prdata = {30'd0, r_cfg.enable_mode};
            REG_ON_MODE:       prdata = {30'd0, r_cfg.on_mode};
            REG_ON_THRESHOLD:  prdata = {{16{r_cfg.on_threshold[15]}}, r_cfg.on_threshold};
            REG_OFF_MODE:      prdata = {30'd0, r_cfg.off_mode};
            REG_OFF_THRESHOLD: prdata = {{16{r_cfg.off_threshold[15]}}, r_cfg.off_threshold};
            REG_OPTION_FLAGS:  prdata = {30'd0, r_cfg.option_flags};
            default:           prdata = '0;
        endcase
    end

endmodule

// File: rtl/ttrt_decide.sv
// Window check and on/off rule evaluation for one tick.
module ttrt_decide
    import ttrt_pkg::*;
(
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    input  logic    i_state,
    output t_result o_result
);

    // True when uptime in seconds has reached minutes*60-1 (signed test)
    function automatic logic timer_done(input logic [31:0] uptime,
                                        input logic signed [15:0] minutes);
        logic signed [22:0] ext;
        logic signed [22:0] limit;
        ext   = {{7{minutes[15]}}, minutes};
        limit = (ext <<< 6) - (ext <<< 2) - 23'sd1;
        return limit[22] | (uptime >= {10'd0, limit[21:0]});
    endfunction

    logic signed [12:0] w_minute;
    logic signed [12:0] w_start;
    logic signed [12:0] w_end;
    logic               w_in_window;
    logic               w_important;
    logic               w_present;
    logic               w_on_hit;
    logic               w_off_hit;

    assign w_minute    = $signed({2'b00, i_item.minute_of_day});
    assign w_start     = {i_cfg.window_start[11], i_cfg.window_start};
    assign w_end       = {i_cfg.window_end[11], i_cfg.window_end};
    assign w_important = i_cfg.option_flags[OPT_IMPORTANT];
    assign w_present   = i_cfg.option_flags[OPT_PRESENT];

    // Check the daily window: all day, normal, or wrapping overnight
    always_comb begin
        w_in_window = 1'b0;
        if (i_cfg.enable_mode == EN_TIMED) begin
            w_in_window = (i_cfg.window_start == WINDOW_ALL_DAY)
                | ((w_start <= w_minute) & (w_end > w_minute))
                | ((w_start > w_end) & ((w_start <= w_minute) | (w_end > w_minute)));
        end
    end

    // Evaluate the on rule
    always_comb begin
        unique case (i_cfg.on_mode)
            RULE_BELOW: w_on_hit = !w_present
                | (i_item.sensor_value < i_cfg.on_threshold);
            RULE_ABOVE: w_on_hit = !w_present
                | (i_item.sensor_value > i_cfg.on_threshold);
            RULE_TIMER: w_on_hit = !i_item.output_is_on
                & timer_done(i_item.output_uptime, i_cfg.on_threshold);
            default:    w_on_hit = 1'b0;
        endcase
    end

    // Evaluate the off rule
    always_comb begin
        unique case (i_cfg.off_mode)
            RULE_BELOW: w_off_hit = w_present
                & (i_item.sensor_value <= i_cfg.off_threshold);
            RULE_ABOVE: w_off_hit = w_present
                & (i_item.sensor_value >= i_cfg.off_threshold);
            RULE_TIMER: w_off_hit = i_item.output_is_on
                & timer_done(i_item.output_uptime, i_cfg.off_threshold);
            default:    w_off_hit = 1'b0;
        endcase
    end

    // Pick the commands and the new trigger state
    always_comb begin
        o_result.first_command  = CMD_NONE;
        o_result.second_command = CMD_NONE;
        o_result.trigger_on     = i_state;
        o_result.handled        = 1'b0;
        priority if (i_cfg.enable_mode == EN_FORCED) begin
            o_result.handled = 1'b1;
            if (w_important) begin
                o_result.first_command = CMD_REVIVE;
            end else begin
                o_result.first_command = CMD_ON;
                o_result.trigger_on    = 1'b1;
            end
        end else if (w_in_window) begin
            o_result.handled = 1'b1;
            if (w_on_hit) begin
                if (w_important) begin
                    o_result.first_command = CMD_REVIVE;
                end else begin
                    o_result.first_command = CMD_ON;
                    o_result.trigger_on    = 1'b1;
                end
            end
            if (w_off_hit) begin
                if (w_important) begin
                    o_result.second_command = CMD_KILL;
                end else begin
                    o_result.second_command = CMD_OFF;
                    o_result.trigger_on     = 1'b0;
                end
            end
        end else begin
            o_result.first_command = CMD_OFF;
            o_result.trigger_on    = 1'b0;
            if (w_important) begin
                o_result.second_command = CMD_REVIVE;
            end
        end
    end

endmodule

// File: rtl/timed_threshold_relay_trigger_unit.sv
// Top level of the timed threshold relay trigger unit.
// Usage:
//   Tick items enter on the input channel (i_in_valid / o_in_stall) and one
//   result per tick leaves on the output channel (o_out_valid / i_out_stall).
//   A transfer happens at a rising edge where valid is high and stall low.
//   An accepted tick lands in the input register; the window and rule logic
//   runs between that register and the result register, so the result is
//   offered once the tick has moved on from the input register into the
//   result register, which waits while a held result blocks the output.
//   Without stalls, throughput is one tick per cycle; the only loop is the
//   one-bit trigger state, updated as a tick moves into the result register.
//   When the receiver stalls, the result register holds its payload, the
//   input register still fills, and o_in_stall rises once both are full.
//   Reset (i_rst_n low, synchronous) empties both registers, clears the
//   trigger state and returns configuration to its reset values (all-day
//   window, disabled). Configuration is written over the APB-style port
//   while no tick is in flight, a rule for the user that the block does not enforce.
module timed_threshold_relay_trigger_unit
    import ttrt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [10:0]        i_minute_of_day,
    input  logic signed [15:0] i_sensor_value,
    input  logic               i_output_is_on,
    input  logic [31:0]        i_output_uptime,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_first_command,
    output logic [2:0]         o_second_command,
    output logic               o_trigger_on,
    output logic               o_handled,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_cfg    w_cfg;
    t_result w_result;
    t_item   r_item;
    t_result r_result;
    logic    r_item_valid;
    logic    r_out_valid;
    logic    r_state;
    logic    w_out_free;
    logic    w_advance;
    logic    w_in_take;

    ttrt_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ttrt_decide u_decide (
        .i_cfg    (w_cfg),
        .i_item   (r_item),
        .i_state  (r_state),
        .o_result (w_result)
    );

    // Handshake between the two register stages
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_advance  = r_item_valid && w_out_free;
    assign o_in_stall = r_item_valid && !w_out_free;
    assign w_in_take  = i_in_valid && !o_in_stall;

    // Track occupancy of both stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_state      <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_item_valid <= 1'b1;
            end else if (w_advance) begin
                r_item_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_state     <= w_result.trigger_on;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the tick payload
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_item.minute_of_day <= i_minute_of_day;
            r_item.sensor_value  <= i_sensor_value;
            r_item.output_is_on  <= i_output_is_on;
            r_item.output_uptime <= i_output_uptime;
        end
    end

    // Capture the result payload
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_first_command  = r_result.first_command;
    assign o_second_command = r_result.second_command;
    assign o_trigger_on     = r_result.trigger_on;
    assign o_handled        = r_result.handled;

endmodule
